/* design/wms_pkg.sv */
package wms_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int POS_W          = 24;
    localparam int HEAD_W         = 16;
    localparam int DWELL_W        = 16;
    localparam int TIDX_W         = 4;
    localparam int PCOUNT_W       = 5;
    localparam int BURST_W        = 8;
    localparam int TIME_W         = 32;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_STATUS  = 3'd1,
        OP_MANUAL  = 3'd2,
        OP_PAUSE   = 3'd3,
        OP_RESUME  = 3'd4,
        OP_STOP    = 3'd5,
        OP_RESTART = 3'd6,
        OP_WRITE   = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        ST_NONE        = 4'd0,
        ST_INVALID     = 4'd1,
        ST_STOPPED     = 4'd2,
        ST_PAUSED      = 4'd3,
        ST_WAIT_MANUAL = 4'd4,
        ST_WAIT_DELAY  = 4'd5,
        ST_DISPATCH    = 4'd6,
        ST_WAIT_ARRIVE = 4'd7,
        ST_DWELL       = 4'd8,
        ST_FINISHED    = 4'd9,
        ST_RUNNING     = 4'd10,
        ST_RESTART     = 4'd11
    } status_t;

    typedef enum logic [2:0] {
        TC_NONE        = 3'd0,
        TC_RESUME      = 3'd1,
        TC_PAUSE       = 3'd2,
        TC_STOP        = 3'd3,
        TC_STOP_RESUME = 3'd4
    } tcmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POINT_COUNT  = 3'd0,
        CFG_START_IMMED  = 3'd1,
        CFG_START_DELAY  = 3'd2,
        CFG_LOOP_ROUTE   = 3'd3,
        CFG_BURST_COUNT  = 3'd4,
        CFG_DEFAULT_DWELL = 3'd5
    } cfg_index_t;

    typedef enum logic [4:0] {
        PH_WAIT   = 5'b00001,
        PH_DISP   = 5'b00010,
        PH_ARRIVE = 5'b00100,
        PH_DWELL  = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    typedef struct packed {
        op_t                      op;
        logic                     tracker_finished;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [HEAD_W-1:0] heading;
        logic [DWELL_W-1:0]       dwell_ticks_in;
        logic [TIDX_W-1:0]        table_index;
    } item_t;

    typedef struct packed {
        status_t                  status;
        tcmd_t                    tracker_cmd;
        logic                     goal_send;
        logic signed [POS_W-1:0]  goal_x;
        logic signed [POS_W-1:0]  goal_y;
        logic signed [HEAD_W-1:0] goal_heading;
        logic [TIDX_W-1:0]        current_point;
        logic                     manual_mode;
        logic                     is_paused;
        logic                     is_stopped;
    } result_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [HEAD_W-1:0] heading;
        logic [DWELL_W-1:0]       dwell;
    } wp_t;

endpackage

/* design/wms_if.sv */
interface wms_item_if;
    import wms_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wms_result_if;
    import wms_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/wms_point_table.sv */
module wms_point_table #(
    parameter int MAX_POINTS = wms_pkg::MAX_POINTS_DEF,
    parameter int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [wms_pkg::TIDX_W-1:0] wr_index,
    input  wms_pkg::wp_t             wr_data,
    input  logic [IDX_W-1:0]         rd_base,
    output wms_pkg::wp_t             first,
    output wms_pkg::wp_t             nxt
);
    import wms_pkg::*;

    localparam int AW = (IDX_W > TIDX_W) ? IDX_W : TIDX_W;

    wp_t             mem [MAX_POINTS];
    wp_t             first_reg;
    wp_t             nxt_reg;
    logic [AW-1:0]   wr_wide;
    logic            wr_hit;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W:0]  inc;
    logic [IDX_W-1:0] rd_addr;

    always_comb
    begin
        wr_wide = AW'(wr_index);
        wr_hit  = wr_en && ({1'b0, wr_wide} < (AW+1)'(MAX_POINTS));
        wr_addr = wr_wide[IDX_W-1:0];
        inc     = {1'b0, rd_base} + (IDX_W+1)'(1);
        if (inc < (IDX_W+1)'(MAX_POINTS))
        begin
            rd_addr = inc[IDX_W-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_hit && (wr_addr == rd_addr))
        begin
            nxt_reg <= wr_data;
        end
        else
        begin
            nxt_reg <= mem[rd_addr];
        end
        if (wr_hit && (wr_addr == '0))
        begin
            first_reg <= wr_data;
        end
    end

    assign first = first_reg;
    assign nxt   = nxt_reg;

endmodule

/* design/waypoint_mission_sequencer.sv */
// Waypoint mission sequencer. Takes one request per clock on the item channel
// and returns exactly one result per request on the result channel: the
// request waits in the input register and its result in the result register,
// with all sequencing done in a single pass between them. Sustained rate is
// one request per clock; backpressure on the result side stalls the input
// side only once both registers are full. The point table is a memory with a
// registered read that tracks the point after the current one; a table entry
// must be written before the route reaches it. Configuration writes belong to
// idle periods only.
module waypoint_mission_sequencer #(
    parameter int MAX_POINTS = wms_pkg::MAX_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [wms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    wms_item_if.sink                        item,
    wms_result_if.source                    result
);
    import wms_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = (IDX_W + 1 > PCOUNT_W) ? IDX_W + 1 : PCOUNT_W;
    localparam int CW    = (IDX_W > TIDX_W) ? IDX_W : TIDX_W;

    logic [PCOUNT_W-1:0] point_count_reg;
    logic                start_imm_reg;
    logic [15:0]         start_delay_reg;
    logic                loop_route_reg;
    logic [BURST_W-1:0]  burst_reg;
    logic [DWELL_W-1:0]  def_dwell_reg;

    logic  s1_valid_reg;
    item_t s1_data_reg;
    logic  out_valid_reg;
    result_t out_data_reg;
    logic  fire;

    phase_t              phase_reg, phase_next;
    logic [IDX_W-1:0]    point_idx_reg, point_idx_next;
    logic [BURST_W-1:0]  sends_reg, sends_next;
    logic [TIME_W-1:0]   tick_reg, tick_next;
    logic [TIME_W-1:0]   start_stamp_reg, start_stamp_next;
    logic                started_reg, started_next;
    logic [TIME_W-1:0]   dwell_stamp_reg, dwell_stamp_next;
    logic                arrived_reg, arrived_next;
    logic                pause_reg, pause_next;
    logic                stop_reg, stop_next;
    logic                manual_reg, manual_next;
    logic signed [POS_W-1:0]  act_x_reg, act_x_next;
    logic signed [POS_W-1:0]  act_y_reg, act_y_next;
    logic signed [HEAD_W-1:0] act_h_reg, act_h_next;
    logic [DWELL_W-1:0]  cur_dwell_reg, cur_dwell_next;

    wp_t                 wp_first;
    wp_t                 wp_nxt;
    wp_t                 wr_wp;
    logic                tbl_we;
    result_t             res;

    logic [CNT_W-1:0]    n_pts;
    logic [CNT_W-1:0]    pc_wide;
    logic [CNT_W-1:0]    succ;
    logic                go_en;
    logic                go_first;
    logic                ticking;
    status_t             st;
    tcmd_t               tcmd;
    logic                send;
    logic [DWELL_W-1:0]  dw;
    logic [CW-1:0]       wr_cmp;
    logic [CW-1:0]       pt_cmp;

    assign fire       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || fire;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    assign tbl_we = fire && (s1_data_reg.op == OP_WRITE);
    always_comb
    begin
        wr_wp.x       = s1_data_reg.pos_x;
        wr_wp.y       = s1_data_reg.pos_y;
        wr_wp.heading = s1_data_reg.heading;
        wr_wp.dwell   = s1_data_reg.dwell_ticks_in;
    end

    wms_point_table #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk      (clk),
        .wr_en    (tbl_we),
        .wr_index (s1_data_reg.table_index),
        .wr_data  (wr_wp),
        .rd_base  (point_idx_next),
        .first    (wp_first),
        .nxt      (wp_nxt)
    );

    always_comb
    begin
        pc_wide = CNT_W'(point_count_reg);
        if (pc_wide > CNT_W'(MAX_POINTS))
        begin
            n_pts = CNT_W'(MAX_POINTS);
        end
        else
        begin
            n_pts = pc_wide;
        end
        succ = CNT_W'(point_idx_reg) + CNT_W'(1);
    end

    always_comb
    begin
        phase_next       = phase_reg;
        point_idx_next   = point_idx_reg;
        sends_next       = sends_reg;
        tick_next        = tick_reg;
        start_stamp_next = start_stamp_reg;
        started_next     = started_reg;
        dwell_stamp_next = dwell_stamp_reg;
        arrived_next     = arrived_reg;
        pause_next       = pause_reg;
        stop_next        = stop_reg;
        manual_next      = manual_reg;
        act_x_next       = act_x_reg;
        act_y_next       = act_y_reg;
        act_h_next       = act_h_reg;
        cur_dwell_next   = cur_dwell_reg;
        st               = ST_NONE;
        tcmd             = TC_NONE;
        send             = 1'b0;
        go_en            = 1'b0;
        go_first         = 1'b0;
        ticking          = 1'b0;
        dw               = def_dwell_reg;
        wr_cmp           = CW'(s1_data_reg.table_index);
        pt_cmp           = CW'(point_idx_reg);

        if (fire)
        begin
            unique case (s1_data_reg.op)
                OP_TICK:
                begin
                    tick_next = tick_reg + TIME_W'(1);
                    if (n_pts == '0)
                    begin
                        st = ST_INVALID;
                    end
                    else
                    begin
                        if (!started_reg)
                        begin
                            started_next     = 1'b1;
                            start_stamp_next = tick_reg;
                        end
                        priority if (stop_reg)
                        begin
                            st = ST_STOPPED;
                        end
                        else if (pause_reg)
                        begin
                            st = ST_PAUSED;
                        end
                        else if (phase_reg == PH_WAIT && !start_imm_reg)
                        begin
                            st = ST_WAIT_MANUAL;
                        end
                        else if (phase_reg == PH_WAIT &&
                                 (tick_reg - start_stamp_next) < TIME_W'(start_delay_reg))
                        begin
                            st = ST_WAIT_DELAY;
                        end
                        else
                        begin
                            ticking = 1'b1;
                            if (phase_reg == PH_WAIT)
                            begin
                                tcmd     = TC_RESUME;
                                go_en    = 1'b1;
                                go_first = 1'b1;
                            end
                        end
                    end
                end
                OP_STATUS:
                begin
                    arrived_next = s1_data_reg.tracker_finished;
                end
                OP_MANUAL:
                begin
                    act_x_next   = s1_data_reg.pos_x;
                    act_y_next   = s1_data_reg.pos_y;
                    act_h_next   = s1_data_reg.heading;
                    manual_next  = 1'b1;
                    stop_next    = 1'b0;
                    pause_next   = 1'b0;
                    tcmd         = TC_RESUME;
                    phase_next   = PH_DISP;
                    sends_next   = '0;
                    arrived_next = 1'b0;
                end
                OP_PAUSE:
                begin
                    if (!stop_reg)
                    begin
                        pause_next = 1'b1;
                        tcmd       = TC_PAUSE;
                        st         = ST_PAUSED;
                    end
                end
                OP_RESUME:
                begin
                    if (!stop_reg)
                    begin
                        pause_next = 1'b0;
                        tcmd       = TC_RESUME;
                        st         = ST_RUNNING;
                    end
                end
                OP_STOP:
                begin
                    pause_next = 1'b0;
                    stop_next  = 1'b1;
                    tcmd       = TC_STOP;
                    st         = ST_STOPPED;
                end
                OP_RESTART:
                begin
                    if (n_pts != '0)
                    begin
                        go_en    = 1'b1;
                        go_first = 1'b1;
                        tcmd     = TC_STOP_RESUME;
                        st       = ST_RESTART;
                    end
                end
                OP_WRITE:
                begin
                    if (wr_cmp == pt_cmp)
                    begin
                        cur_dwell_next = s1_data_reg.dwell_ticks_in;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // start of route: load the first point before the phase step
        if (go_en)
        begin
            point_idx_next = '0;
            manual_next    = 1'b0;
            stop_next      = 1'b0;
            pause_next     = 1'b0;
            act_x_next     = wp_first.x;
            act_y_next     = wp_first.y;
            act_h_next     = wp_first.heading;
            cur_dwell_next = wp_first.dwell;
            phase_next     = PH_DISP;
            sends_next     = '0;
            arrived_next   = 1'b0;
        end

        if (ticking)
        begin
            if (!manual_reg)
            begin
                dw = cur_dwell_reg;
            end
            unique case (phase_next)
                PH_DISP:
                begin
                    send       = 1'b1;
                    sends_next = sends_next + BURST_W'(1);
                    if (sends_next >= burst_reg)
                    begin
                        phase_next = PH_ARRIVE;
                    end
                    st = ST_DISPATCH;
                end
                PH_ARRIVE:
                begin
                    if (arrived_reg)
                    begin
                        dwell_stamp_next = tick_reg;
                        phase_next       = PH_DWELL;
                    end
                    st = ST_WAIT_ARRIVE;
                end
                PH_DWELL:
                begin
                    st = ST_DWELL;
                    if ((tick_reg - dwell_stamp_reg) >= TIME_W'(dw))
                    begin
                        priority if (manual_reg)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (succ < n_pts)
                        begin
                            tcmd           = TC_RESUME;
                            point_idx_next = point_idx_reg + IDX_W'(1);
                            manual_next    = 1'b0;
                            stop_next      = 1'b0;
                            pause_next     = 1'b0;
                            act_x_next     = wp_nxt.x;
                            act_y_next     = wp_nxt.y;
                            act_h_next     = wp_nxt.heading;
                            cur_dwell_next = wp_nxt.dwell;
                            phase_next     = PH_DISP;
                            sends_next     = '0;
                            arrived_next   = 1'b0;
                        end
                        else if (loop_route_reg)
                        begin
                            tcmd           = TC_RESUME;
                            point_idx_next = '0;
                            manual_next    = 1'b0;
                            stop_next      = 1'b0;
                            pause_next     = 1'b0;
                            act_x_next     = wp_first.x;
                            act_y_next     = wp_first.y;
                            act_h_next     = wp_first.heading;
                            cur_dwell_next = wp_first.dwell;
                            phase_next     = PH_DISP;
                            sends_next     = '0;
                            arrived_next   = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_DONE:
                begin
                    st = ST_FINISHED;
                end
                default:
                begin
                    st = ST_NONE;
                end
            endcase
        end
    end

    always_comb
    begin
        res.status        = st;
        res.tracker_cmd   = tcmd;
        res.goal_send     = send;
        res.goal_x        = act_x_next;
        res.goal_y        = act_y_next;
        res.goal_heading  = act_h_next;
        res.current_point = TIDX_W'({{TIDX_W{1'b0}}, point_idx_next});
        res.manual_mode   = manual_next;
        res.is_paused     = pause_next;
        res.is_stopped    = stop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= PCOUNT_W'(1);
            start_imm_reg   <= 1'b1;
            start_delay_reg <= 16'd8;
            loop_route_reg  <= 1'b0;
            burst_reg       <= BURST_W'(3);
            def_dwell_reg   <= DWELL_W'(5);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POINT_COUNT:   point_count_reg <= cfg_wdata[PCOUNT_W-1:0];
                CFG_START_IMMED:   start_imm_reg   <= cfg_wdata[0];
                CFG_START_DELAY:   start_delay_reg <= cfg_wdata[15:0];
                CFG_LOOP_ROUTE:    loop_route_reg  <= cfg_wdata[0];
                CFG_BURST_COUNT:   burst_reg       <= cfg_wdata[BURST_W-1:0];
                CFG_DEFAULT_DWELL: def_dwell_reg   <= cfg_wdata[DWELL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                s1_valid_reg <= item.valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            s1_data_reg <= item.data;
        end
        if (fire)
        begin
            out_data_reg  <= res;
            cur_dwell_reg <= cur_dwell_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT;
            point_idx_reg   <= '0;
            sends_reg       <= '0;
            tick_reg        <= '0;
            start_stamp_reg <= '0;
            started_reg     <= 1'b0;
            dwell_stamp_reg <= '0;
            arrived_reg     <= 1'b0;
            pause_reg       <= 1'b0;
            stop_reg        <= 1'b0;
            manual_reg      <= 1'b0;
            act_x_reg       <= '0;
            act_y_reg       <= '0;
            act_h_reg       <= '0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            point_idx_reg   <= point_idx_next;
            sends_reg       <= sends_next;
            tick_reg        <= tick_next;
            start_stamp_reg <= start_stamp_next;
            started_reg     <= started_next;
            dwell_stamp_reg <= dwell_stamp_next;
            arrived_reg     <= arrived_next;
            pause_reg       <= pause_next;
            stop_reg        <= stop_next;
            manual_reg      <= manual_next;
            act_x_reg       <= act_x_next;
            act_y_reg       <= act_y_next;
            act_h_reg       <= act_h_next;
        end
    end

endmodule

/* design/wms_checker.sv */
module wms_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input wms_pkg::result_t    res_data
);
    import wms_pkg::*;

    a_send_only_on_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.goal_send) |-> (res_data.status == ST_DISPATCH))
        else $error("goal sent outside dispatch");

    a_stop_clears_pause: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.is_stopped) |-> !res_data.is_paused)
        else $error("paused and stopped at once");

    a_restart_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.status == ST_RESTART) |->
        (res_data.tracker_cmd == TC_STOP_RESUME && res_data.current_point == '0 &&
         !res_data.manual_mode && !res_data.is_stopped))
        else $error("restart result malformed");

    a_stop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.tracker_cmd == TC_STOP) |-> res_data.is_stopped)
        else $error("stop command without stop flag");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
        else $error("stalled result changed");

endmodule

bind waypoint_mission_sequencer wms_checker u_wms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);

/* tb/mission_checker.sv */
`timescale 1ns / 1ps
module mission_checker
    import wms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    wms_item_if                    item_ch,
    wms_result_if                  result_ch,
    output int                     mismatches,
    output int                     outstanding,
    output int                     reports_checked,
    output logic [15:0]            statuses_seen
);

    localparam int POINTS = MAX_POINTS_DEF;

    logic [PCOUNT_W-1:0] cfg_points;
    logic                cfg_auto_start;
    logic [15:0]         cfg_delay;
    logic                cfg_loop;
    logic [BURST_W-1:0]  cfg_burst;
    logic [DWELL_W-1:0]  cfg_dwell;

    phase_t                   route_phase;
    logic [TIDX_W-1:0]        cur_point;
    logic [BURST_W-1:0]       burst_sent;
    logic [TIME_W-1:0]        tick_clock;
    logic [TIME_W-1:0]        start_mark;
    logic [TIME_W-1:0]        dwell_mark;
    logic                     clock_started;
    logic                     arrival_ok;
    logic                     paused;
    logic                     stopped;
    logic                     manual_goal;
    logic signed [POS_W-1:0]  goal_x;
    logic signed [POS_W-1:0]  goal_y;
    logic signed [HEAD_W-1:0] goal_heading;
    wp_t                      route_table [POINTS];

    result_t awaited_reports [$];

    function automatic void enter_point(input logic [TIDX_W-1:0] idx);
        cur_point    = idx;
        manual_goal  = 1'b0;
        stopped      = 1'b0;
        paused       = 1'b0;
        goal_x       = route_table[idx].x;
        goal_y       = route_table[idx].y;
        goal_heading = route_table[idx].heading;
        route_phase  = PH_DISP;
        burst_sent   = '0;
        arrival_ok   = 1'b0;
    endfunction

    function automatic result_t sequence_request(input item_t req);
        result_t            rsp;
        logic [PCOUNT_W-1:0] used;
        logic [TIME_W-1:0]  now;
        logic [DWELL_W-1:0] hold;
        logic               advance;
        rsp = '0;
        rsp.status = ST_NONE;
        rsp.tracker_cmd = TC_NONE;
        used = (cfg_points > PCOUNT_W'(POINTS)) ? PCOUNT_W'(POINTS) : cfg_points;
        case (req.op)
            OP_TICK:
            begin
                now = tick_clock;
                tick_clock = tick_clock + 1;
                advance = 1'b0;
                if (used == 0)
                    rsp.status = ST_INVALID;
                else
                begin
                    if (!clock_started)
                    begin
                        clock_started = 1'b1;
                        start_mark = now;
                    end
                    if (stopped)
                        rsp.status = ST_STOPPED;
                    else if (paused)
                        rsp.status = ST_PAUSED;
                    else if (route_phase == PH_WAIT)
                    begin
                        if (!cfg_auto_start)
                            rsp.status = ST_WAIT_MANUAL;
                        else if (now - start_mark < {16'd0, cfg_delay})
                            rsp.status = ST_WAIT_DELAY;
                        else
                        begin
                            rsp.tracker_cmd = TC_RESUME;
                            enter_point('0);
                            advance = 1'b1;
                        end
                    end
                    else
                        advance = 1'b1;
                end
                if (advance)
                begin
                    case (route_phase)
                        PH_DISP:
                        begin
                            rsp.status = ST_DISPATCH;
                            rsp.goal_send = 1'b1;
                            burst_sent = burst_sent + 1'b1;
                            if (burst_sent >= cfg_burst)
                                route_phase = PH_ARRIVE;
                        end
                        PH_ARRIVE:
                        begin
                            rsp.status = ST_WAIT_ARRIVE;
                            if (arrival_ok)
                            begin
                                dwell_mark = now;
                                route_phase = PH_DWELL;
                            end
                        end
                        PH_DWELL:
                        begin
                            rsp.status = ST_DWELL;
                            hold = manual_goal ? cfg_dwell : route_table[cur_point].dwell;
                            if (now - dwell_mark >= {16'd0, hold})
                            begin
                                if (manual_goal)
                                    route_phase = PH_DONE;
                                else if ({1'b0, cur_point} + 5'd1 < used)
                                begin
                                    rsp.tracker_cmd = TC_RESUME;
                                    enter_point(cur_point + 1'b1);
                                end
                                else if (cfg_loop)
                                begin
                                    rsp.tracker_cmd = TC_RESUME;
                                    enter_point('0);
                                end
                                else
                                    route_phase = PH_DONE;
                            end
                        end
                        PH_DONE:
                            rsp.status = ST_FINISHED;
                        default:
                            rsp.status = ST_NONE;
                    endcase
                end
            end
            OP_STATUS:
                arrival_ok = req.tracker_finished;
            OP_MANUAL:
            begin
                goal_x = req.pos_x;
                goal_y = req.pos_y;
                goal_heading = req.heading;
                manual_goal = 1'b1;
                stopped = 1'b0;
                paused = 1'b0;
                rsp.tracker_cmd = TC_RESUME;
                route_phase = PH_DISP;
                burst_sent = '0;
                arrival_ok = 1'b0;
            end
            OP_PAUSE:
            begin
                if (!stopped)
                begin
                    paused = 1'b1;
                    rsp.tracker_cmd = TC_PAUSE;
                    rsp.status = ST_PAUSED;
                end
            end
            OP_RESUME:
            begin
                if (!stopped)
                begin
                    paused = 1'b0;
                    rsp.tracker_cmd = TC_RESUME;
                    rsp.status = ST_RUNNING;
                end
            end
            OP_STOP:
            begin
                paused = 1'b0;
                stopped = 1'b1;
                rsp.tracker_cmd = TC_STOP;
                rsp.status = ST_STOPPED;
            end
            OP_RESTART:
            begin
                if (used != 0)
                begin
                    enter_point('0);
                    rsp.tracker_cmd = TC_STOP_RESUME;
                    rsp.status = ST_RESTART;
                end
            end
            default:
            begin
                route_table[req.table_index].x = req.pos_x;
                route_table[req.table_index].y = req.pos_y;
                route_table[req.table_index].heading = req.heading;
                route_table[req.table_index].dwell = req.dwell_ticks_in;
            end
        endcase
        rsp.goal_x = goal_x;
        rsp.goal_y = goal_y;
        rsp.goal_heading = goal_heading;
        rsp.current_point = cur_point;
        rsp.manual_mode = manual_goal;
        rsp.is_paused = paused;
        rsp.is_stopped = stopped;
        return rsp;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] result %0d %s: got 0x%0h, want 0x%0h",
                     $time, reports_checked, field, got, want);
    endtask

    task automatic check_report(input result_t got, input result_t want);
        if (got.status !== want.status)
            flag_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.tracker_cmd !== want.tracker_cmd)
            flag_mismatch("tracker_cmd", 32'(got.tracker_cmd), 32'(want.tracker_cmd));
        if (got.goal_send !== want.goal_send)
            flag_mismatch("goal_send", 32'(got.goal_send), 32'(want.goal_send));
        if (got.goal_x !== want.goal_x)
            flag_mismatch("goal_x", 32'(got.goal_x), 32'(want.goal_x));
        if (got.goal_y !== want.goal_y)
            flag_mismatch("goal_y", 32'(got.goal_y), 32'(want.goal_y));
        if (got.goal_heading !== want.goal_heading)
            flag_mismatch("goal_heading", 32'(got.goal_heading), 32'(want.goal_heading));
        if (got.current_point !== want.current_point)
            flag_mismatch("current_point", 32'(got.current_point),
                          32'(want.current_point));
        if (got.manual_mode !== want.manual_mode)
            flag_mismatch("manual_mode", 32'(got.manual_mode), 32'(want.manual_mode));
        if (got.is_paused !== want.is_paused)
            flag_mismatch("is_paused", 32'(got.is_paused), 32'(want.is_paused));
        if (got.is_stopped !== want.is_stopped)
            flag_mismatch("is_stopped", 32'(got.is_stopped), 32'(want.is_stopped));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            cfg_points      = 5'd1;
            cfg_auto_start  = 1'b1;
            cfg_delay       = 16'd8;
            cfg_loop        = 1'b0;
            cfg_burst       = 8'd3;
            cfg_dwell       = 16'd5;
            route_phase     = PH_WAIT;
            cur_point       = '0;
            burst_sent      = '0;
            tick_clock      = '0;
            start_mark      = '0;
            dwell_mark      = '0;
            clock_started   = 1'b0;
            arrival_ok      = 1'b0;
            paused          = 1'b0;
            stopped         = 1'b0;
            manual_goal     = 1'b0;
            goal_x          = '0;
            goal_y          = '0;
            goal_heading    = '0;
            for (int k = 0; k < POINTS; k++)
                route_table[k] = '0;
            awaited_reports.delete();
            mismatches      = 0;
            outstanding     = 0;
            reports_checked = 0;
            statuses_seen   = '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_POINT_COUNT:   cfg_points = cfg_wdata[PCOUNT_W-1:0];
                    CFG_START_IMMED:   cfg_auto_start = cfg_wdata[0];
                    CFG_START_DELAY:   cfg_delay = cfg_wdata;
                    CFG_LOOP_ROUTE:    cfg_loop = cfg_wdata[0];
                    CFG_BURST_COUNT:   cfg_burst = cfg_wdata[BURST_W-1:0];
                    CFG_DEFAULT_DWELL: cfg_dwell = cfg_wdata[DWELL_W-1:0];
                    default: ;
                endcase
            end
            if (item_ch.valid && item_ch.ready)
                awaited_reports.insert(awaited_reports.size(),
                                       sequence_request(item_ch.data));
            if (result_ch.valid && result_ch.ready)
            begin
                reports_checked++;
                statuses_seen[result_ch.data.status] = 1'b1;
                if (awaited_reports.size() == 0)
                    flag_mismatch("unexpected result", 32'(result_ch.data.status), '0);
                else
                begin
                    want = awaited_reports.pop_front();
                    check_report(result_ch.data, want);
                end
            end
            outstanding = awaited_reports.size();
        end
    end

endmodule

/* tb/tb_waypoint_mission_sequencer.sv */
`timescale 1ns / 1ps
module tb_waypoint_mission_sequencer;
    import wms_pkg::*;

    localparam int HOLD_OFF_CYCLES = 60;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    wms_item_if   item_ch ();
    wms_result_if result_ch ();

    int          mismatches;
    int          outstanding;
    int          reports_checked;
    logic [15:0] statuses_seen;
    int          requests_sent;
    int          settings_loaded;
    bit          sender_idles;
    bit          sink_idles;
    bit          hold_off_req;

    waypoint_mission_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    mission_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .item_ch         (item_ch),
        .result_ch       (result_ch),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .reports_checked (reports_checked),
        .statuses_seen   (statuses_seen)
    );

    always #5 clk = ~clk;

    function automatic item_t build_request(input op_t op, input logic fin,
                                            input logic [POS_W-1:0] x,
                                            input logic [POS_W-1:0] y,
                                            input logic [HEAD_W-1:0] h,
                                            input logic [DWELL_W-1:0] dw,
                                            input logic [TIDX_W-1:0] idx);
        item_t r;
        r.op = op;
        r.tracker_finished = fin;
        r.pos_x = x;
        r.pos_y = y;
        r.heading = h;
        r.dwell_ticks_in = dw;
        r.table_index = idx;
        return r;
    endfunction

    function automatic item_t random_request();
        item_t r;
        int    pick;
        r = build_request(OP_TICK, $urandom_range(0, 9) < 8, POS_W'($urandom),
                          POS_W'($urandom), HEAD_W'($urandom), DWELL_W'($urandom),
                          TIDX_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 52)
            r.op = OP_TICK;
        else if (pick < 68)
            r.op = OP_STATUS;
        else if (pick < 72)
            r.op = OP_MANUAL;
        else if (pick < 76)
            r.op = OP_PAUSE;
        else if (pick < 81)
            r.op = OP_RESUME;
        else if (pick < 83)
            r.op = OP_STOP;
        else if (pick < 87)
            r.op = OP_RESTART;
        else
        begin
            r.op = OP_WRITE;
            // keep dwell short so the route moves on
            if ($urandom_range(0, 29) != 0)
                r.dwell_ticks_in = DWELL_W'($urandom_range(0, 6));
        end
        return r;
    endfunction

    // hold valid across back-to-back requests; return at the falling edge
    task automatic offer_request(input item_t r);
        item_ch.valid <= 1'b1;
        item_ch.data <= r;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        item_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic put_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [15:0] points, input logic [15:0] auto_start,
                                 input logic [15:0] delay, input logic [15:0] loop_back,
                                 input logic [15:0] burst, input logic [15:0] dwell);
        put_register(CFG_POINT_COUNT, points);
        put_register(CFG_START_IMMED, auto_start);
        put_register(CFG_START_DELAY, delay);
        put_register(CFG_LOOP_ROUTE, loop_back);
        put_register(CFG_BURST_COUNT, burst);
        put_register(CFG_DEFAULT_DWELL, dwell);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic run_random(input int count, input bit may_idle);
        for (int k = 0; k < count; k++)
        begin
            if (k % 64 == 0)
            begin
                sender_idles = may_idle && ($urandom_range(0, 3) != 0);
                sink_idles = may_idle && ($urandom_range(0, 3) != 0);
            end
            if (sender_idles && $urandom_range(0, 4) == 0)
            begin
                item_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            if (may_idle && $urandom_range(0, 299) == 0)
                settle();
            offer_request(random_request());
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else if (sink_idles && $urandom_range(0, 2) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        result_ch.ready = 1'b0;
        sender_idles = 1'b1;
        sink_idles = 1'b1;
        hold_off_req = 1'b0;
        requests_sent = 0;
        settings_loaded = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fill the whole table before any tick can start the route
        offer_request(build_request(OP_WRITE, 1'b0, 24'h7FFFFF, 24'h800000, 16'h7FFF,
                                    16'd0, 4'd0));
        offer_request(build_request(OP_WRITE, 1'b1, 24'h800000, 24'h7FFFFF, 16'h8000,
                                    16'hFFFF, 4'd15));
        for (int i = 1; i < 15; i++)
            offer_request(build_request(OP_WRITE, 1'b0, POS_W'($urandom), POS_W'($urandom),
                                        HEAD_W'($urandom), DWELL_W'($urandom_range(1, 4)),
                                        TIDX_W'(i)));
        offer_request(build_request(OP_TICK, 1'b0, '0, '0, '0, '0, '0));
        offer_request(build_request(OP_STATUS, 1'b0, '0, '0, '0, '0, '0));
        offer_request(build_request(OP_STATUS, 1'b1, '0, '0, '0, '0, '0));
        offer_request(build_request(OP_PAUSE, 1'b0, '0, '0, '0, '0, '0));
        offer_request(build_request(OP_TICK, 1'b0, '0, '0, '0, '0, '0));
        offer_request(build_request(OP_RESUME, 1'b0, '0, '0, '0, '0, '0));
        offer_request(build_request(OP_STOP, 1'b0, '0, '0, '0, '0, '0));
        offer_request(build_request(OP_PAUSE, 1'b0, '0, '0, '0, '0, '0));
        offer_request(build_request(OP_RESUME, 1'b0, '0, '0, '0, '0, '0));
        offer_request(build_request(OP_TICK, 1'b0, '0, '0, '0, '0, '0));
        offer_request(build_request(OP_RESTART, 1'b0, '0, '0, '0, '0, '0));
        offer_request(build_request(OP_TICK, 1'b0, '0, '0, '0, '0, '0));
        offer_request(build_request(OP_MANUAL, 1'b0, 24'h800000, 24'h7FFFFF, 16'h8000,
                                    16'hFFFF, 4'hF));
        offer_request(build_request(OP_MANUAL, 1'b1, 24'h7FFFFF, 24'h800000, 16'h7FFF,
                                    16'h0000, 4'h0));

        settle();
        load_settings(16'd16, 16'd1, 16'd0, 16'd1, 16'd1, 16'd0);
        run_random(400, 1'b1);

        // no waypoints: ticks report invalid, restart is dropped
        settle();
        load_settings(16'd0, 16'd1, 16'd8, 16'd0, 16'd3, 16'd5);
        offer_request(build_request(OP_TICK, 1'b0, '0, '0, '0, '0, '0));
        offer_request(build_request(OP_RESTART, 1'b0, '0, '0, '0, '0, '0));
        offer_request(build_request(OP_MANUAL, 1'b0, 24'h123456, 24'h654321, 16'h1234,
                                    16'd0, 4'd0));
        offer_request(build_request(OP_TICK, 1'b0, '0, '0, '0, '0, '0));
        run_random(100, 1'b1);

        settle();
        load_settings(16'd4, 16'd1, 16'd3, 16'd1, 16'd2, 16'd3);
        run_random(200, 1'b1);
        // stall results long enough to back up the input side
        hold_off_req = 1'b1;
        sender_idles = 1'b0;
        repeat (50) offer_request(random_request());
        run_random(200, 1'b1);

        settle();
        load_settings(16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd255, 16'hFFFF);
        run_random(200, 1'b1);

        settle();
        load_settings(16'd16, 16'd1, 16'd2, 16'd0, 16'd4, 16'd2);
        run_random(400, 1'b1);

        settle();
        load_settings(16'd3, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        sink_idles = 1'b0;
        run_random(400, 1'b0);

        item_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Sent %0d requests and checked %0d results across %0d register settings.",
                 requests_sent, reports_checked, settings_loaded);
        $display("Status codes observed (bit mask): 0x%04h", statuses_seen);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
